>>> design/keyframe_transform_sampler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyframe transform sampler
// Same-cycle and next-cycle implication checks on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_TRANSFORM_SAMPLER_TOP_MACROS_SVH
`define KEYFRAME_TRANSFORM_SAMPLER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define KTS_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");
`define KTS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");
`else
`define KTS_ASSERT_SAME(label, pre, post)
`define KTS_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> design/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Sequencer states, register indexes and component layout of the sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

    localparam int NCOMP    = 10;
    localparam int ROT_BASE = 3;
    localparam int ROT_LAST = 6;

    // register index as seen on paddr[2]
    localparam logic REG_KEY_COUNT     = 1'b0;
    localparam logic REG_CLIP_DURATION = 1'b1;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_SMOOTH = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FIRST_RD,
        ST_FIRST_CHK,
        ST_LAST_CHK,
        ST_SCAN,
        ST_FRAC,
        ST_FRAC_DIV,
        ST_SM_A,
        ST_SM_B,
        ST_SM_C,
        ST_LA,
        ST_LB,
        ST_LM,
        ST_LS,
        ST_HALVE,
        ST_SQ,
        ST_SQACC,
        ST_SQRT,
        ST_NORM_START,
        ST_NORM_DIV,
        ST_RAW_RD,
        ST_RAW_WR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> design/keyframe_transform_sampler_top.sv
// ----------------------------------------------------------------------------
// keyframe_transform_sampler_top
// One animation track: key table, time wrap, key search, t by division,
// optional smoothstep, lerp of ten components, quaternion renormalization.
//
//   channel   | direction | handshake          | word
//   ----------+-----------+--------------------+-------------------------------
//   s_        | in        | s_valid / s_ready  | load key component or sample
//   m_        | out       | m_valid / m_ready  | present + ten Q components
//   apb       | in        | psel/penable/pready| key_count, clip_duration
//
// A load word is written to the key tables as it is accepted. A sample word on
// an empty track goes straight to the output; otherwise a time wrap runs when
// clip_duration is set, then a key search (one key memory read per cycle),
// then either a copy of a clamped or stepped key or an interpolation: divisions
// on the shared restoring divider (one for t, four for normalizing), the shared
// multiplier for each component, and the square root. s_ready is low while a
// sample is in work; a finished result waits in the output register without
// holding up the next word.
// Synchronous active-low reset clears control state and registers only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyframe_transform_sampler_top_macros.svh"

module keyframe_transform_sampler_top #(
    parameter int MAX_KEYS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input words
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_opcode,
    input  wire logic [3:0]         s_key_index,
    input  wire logic signed [31:0] s_key_stamp,
    input  wire logic [1:0]         s_key_mode,
    input  wire logic [3:0]         s_component_index,
    input  wire logic signed [31:0] s_component_value,
    input  wire logic signed [31:0] s_sample_time,
    // result words
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_present,
    output logic signed [31:0]      m_trans_x,
    output logic signed [31:0]      m_trans_y,
    output logic signed [31:0]      m_trans_z,
    output logic signed [31:0]      m_rot_x,
    output logic signed [31:0]      m_rot_y,
    output logic signed [31:0]      m_rot_z,
    output logic signed [31:0]      m_rot_w,
    output logic signed [31:0]      m_scale_x,
    output logic signed [31:0]      m_scale_y,
    output logic signed [31:0]      m_scale_z
);
    import kts_pkg::*;

    localparam int KAW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CDEPTH = MAX_KEYS * NCOMP;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int QW     = FRAC_BITS + 1;
    localparam logic [QW-1:0]   T_ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW+1:0]   T_THREE    = (QW+2)'(3) << FRAC_BITS;
    localparam logic [8:0]      MAX_KEYS_9 = 9'(MAX_KEYS);
    localparam logic [4:0]      DIV_STEPS  = 5'(QW - 1);

    function automatic logic [CAW-1:0] comp_base(input logic [KAW-1:0] k);
        logic [CAW+3:0] w;
        w = (CAW+4)'(k) * (CAW+4)'(NCOMP);
        return w[CAW-1:0];
    endfunction

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [4:0]  key_count_reg;
    logic [30:0] clip_duration_reg;

    logic signed [31:0] time_reg;
    logic [KAW-1:0] n_last_reg, idx_reg, ka_reg, kb_reg;
    logic signed [31:0] ta_reg, tb_reg;
    logic [1:0]  mode_a_reg;
    logic [QW-1:0] t_reg;
    logic [3:0]  cidx_reg;
    logic [CAW-1:0] base_a_reg, base_b_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] res_reg [NCOMP];
    logic        present_reg;
    logic        qneg_reg [4];
    logic [31:0] qmag_reg [4];
    logic [31:0] maxm_reg;
    logic [1:0]  qsel_reg;
    logic [63:0] sum_reg, sx_reg, sr_reg, sbit_reg;
    logic [31:0] rem_reg, dvs_reg, dsr_reg;
    logic [QW-1:0] quo_reg;
    logic [4:0]  dcnt_reg;
    logic signed [66:0] prod_reg;

    logic        m_valid_reg, out_present_reg;
    logic signed [31:0] out_res_reg [NCOMP];

    // memories
    logic [33:0]        key_mem [MAX_KEYS];
    logic signed [31:0] comp_mem [CDEPTH];
    logic [33:0]        key_rdata;
    logic signed [31:0] comp_rdata;
    logic [KAW-1:0]     key_rd_addr;
    logic [CAW-1:0]     comp_rd_addr;

    // ---------------- handshake / config ----------------
    logic s_acc, cfg_wr, load_ok;
    logic [8:0] kc9, n9, n_last9, ki9;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_KEY_COUNT:     prdata = {27'd0, key_count_reg};
            REG_CLIP_DURATION: prdata = {1'b0, clip_duration_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg     <= 5'd0;
            clip_duration_reg <= 31'd0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_KEY_COUNT:     key_count_reg     <= pwdata[4:0];
                REG_CLIP_DURATION: clip_duration_reg <= pwdata[30:0];
                default:           key_count_reg     <= key_count_reg;
            endcase
        end
    end

    assign kc9     = {4'd0, key_count_reg};
    assign n9      = (kc9 < MAX_KEYS_9) ? kc9 : MAX_KEYS_9;
    assign n_last9 = n9 - 9'd1;
    assign ki9     = {5'd0, s_key_index};
    assign load_ok = (ki9 < MAX_KEYS_9) && (s_component_index < 4'(NCOMP));

    // ---------------- memories ----------------
    always_ff @(posedge aclk) begin
        if (s_acc && !s_opcode && load_ok) begin
            key_mem[ki9[KAW-1:0]] <= {s_key_mode, s_key_stamp};
        end
        key_rdata <= key_mem[key_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !s_opcode && load_ok) begin
            comp_mem[comp_base(ki9[KAW-1:0]) + CAW'(s_component_index)] <= s_component_value;
        end
        comp_rdata <= comp_mem[comp_rd_addr];
    end

    // ---------------- shared divider and square root ----------------
    logic [32:0] div_trial;
    logic        div_ge, div_last;
    logic [31:0] div_rem_new;
    logic [QW-1:0] div_q_new;
    logic [63:0] sq_try;
    logic        sq_ge;

    assign div_trial   = {rem_reg, dsr_reg[31]};
    assign div_ge      = div_trial >= {1'b0, dvs_reg};
    assign div_rem_new = div_ge ? 32'(div_trial - {1'b0, dvs_reg}) : div_trial[31:0];
    assign div_q_new   = {quo_reg[QW-2:0], div_ge};
    assign div_last    = (dcnt_reg == 5'd0);

    assign sq_try = sr_reg + sbit_reg;
    assign sq_ge  = sx_reg >= sq_try;

    // ---------------- decisions ----------------
    logic signed [31:0] kt;
    logic signed [32:0] frac_num, frac_den;
    logic frac_degen, frac_low, frac_high, is_smooth;

    assign kt         = $signed(key_rdata[31:0]);
    assign frac_num   = $signed({time_reg[31], time_reg}) - $signed({ta_reg[31], ta_reg});
    assign frac_den   = $signed({tb_reg[31], tb_reg}) - $signed({ta_reg[31], ta_reg});
    assign frac_degen = (mode_a_reg == MODE_STEP) || (tb_reg <= ta_reg);
    assign frac_low   = frac_num <= 33'sd0;
    assign frac_high  = frac_num >= frac_den;
    assign is_smooth  = (mode_a_reg == MODE_SMOOTH);

    // ---------------- multiplier operands ----------------
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod_sh;
    logic [QW+1:0]      smooth_w;
    logic signed [32:0] lerp_diff;
    logic signed [33:0] lerp_sum;
    logic signed [31:0] lerp_val;
    logic [1:0]         lerp_q;

    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign smooth_w  = T_THREE - {t_reg, 1'b0};
    assign lerp_diff = $signed({comp_rdata[31], comp_rdata}) - $signed({a_reg[31], a_reg});
    assign lerp_sum  = $signed({{2{a_reg[31]}}, a_reg}) + $signed(prod_sh[33:0]);
    assign lerp_q    = 2'(cidx_reg - 4'(ROT_BASE));

    always_comb begin
        if (lerp_sum > 34'sd2147483647) begin
            lerp_val = 32'sh7fffffff;
        end else if (lerp_sum < -34'sd2147483648) begin
            lerp_val = 32'sh80000000;
        end else begin
            lerp_val = lerp_sum[31:0];
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_opcode) begin
                    if (n9 == 9'd0) begin
                        state_next = ST_DONE;
                    end else if (clip_duration_reg != 31'd0) begin
                        state_next = ST_WRAP;
                    end else begin
                        state_next = ST_FIRST_RD;
                    end
                end
            end
            ST_WRAP:      if (div_last) state_next = ST_FIRST_RD;
            ST_FIRST_RD:  state_next = ST_FIRST_CHK;
            ST_FIRST_CHK: state_next = (time_reg <= kt) ? ST_RAW_RD : ST_LAST_CHK;
            ST_LAST_CHK:  state_next = (time_reg >= kt) ? ST_RAW_RD : ST_SCAN;
            ST_SCAN: begin
                if (time_reg <= kt) begin
                    state_next = ST_FRAC;
                end else if (idx_reg == n_last_reg) begin
                    state_next = ST_RAW_RD;
                end
            end
            ST_FRAC: begin
                if (frac_degen) begin
                    state_next = ST_RAW_RD;
                end else if (!frac_low && !frac_high) begin
                    state_next = ST_FRAC_DIV;
                end else begin
                    state_next = is_smooth ? ST_SM_A : ST_LA;
                end
            end
            ST_FRAC_DIV:  if (div_last) state_next = is_smooth ? ST_SM_A : ST_LA;
            ST_SM_A:      state_next = ST_SM_B;
            ST_SM_B:      state_next = ST_SM_C;
            ST_SM_C:      state_next = ST_LA;
            ST_LA:        state_next = ST_LB;
            ST_LB:        state_next = ST_LM;
            ST_LM:        state_next = ST_LS;
            ST_LS:        state_next = (cidx_reg == 4'(NCOMP - 1)) ? ST_HALVE : ST_LA;
            ST_HALVE:     state_next = (maxm_reg == 32'd0) ? ST_DONE : ST_SQ;
            ST_SQ:        state_next = ST_SQACC;
            ST_SQACC:     state_next = (qsel_reg == 2'd3) ? ST_SQRT : ST_SQ;
            ST_SQRT:      if (div_last) state_next = ST_NORM_START;
            ST_NORM_START: state_next = ST_NORM_DIV;
            ST_NORM_DIV: begin
                if (div_last) begin
                    state_next = (qsel_reg == 2'd3) ? ST_DONE : ST_NORM_START;
                end
            end
            ST_RAW_RD:    state_next = ST_RAW_WR;
            ST_RAW_WR:    state_next = (cidx_reg == 4'(NCOMP - 1)) ? ST_DONE : ST_RAW_RD;
            ST_DONE:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        key_rd_addr  = '0;
        comp_rd_addr = base_a_reg + CAW'(cidx_reg);
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_FIRST_CHK: key_rd_addr = n_last_reg;
            ST_LAST_CHK:  key_rd_addr = KAW'(1);
            ST_SCAN:      key_rd_addr = idx_reg + KAW'(1);
            ST_LB:        comp_rd_addr = base_b_reg + CAW'(cidx_reg);
            ST_SM_A: begin
                mul_a = $signed(34'(t_reg));
                mul_b = $signed(33'(t_reg));
            end
            ST_SM_B: begin
                mul_a = $signed(prod_sh[33:0]);
                mul_b = $signed(33'(smooth_w));
            end
            ST_LM: begin
                mul_a = 34'(lerp_diff);
                mul_b = $signed(33'(t_reg));
            end
            ST_SQ: begin
                mul_a = $signed(34'(qmag_reg[qsel_reg]));
                mul_b = $signed(33'(qmag_reg[qsel_reg]));
            end
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // ---------------- sequencer state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                n_last_reg  <= n_last9[KAW-1:0];
                present_reg <= (n9 != 9'd0);
                time_reg    <= s_sample_time;
                cidx_reg    <= 4'd0;
                for (int i = 0; i < NCOMP; i++) res_reg[i] <= 32'sd0;
                // negative time clamps to zero before the modulo
                rem_reg  <= 32'd0;
                dsr_reg  <= s_sample_time[31] ? 32'd0 : {s_sample_time[30:0], 1'b0};
                dvs_reg  <= {1'b0, clip_duration_reg};
                dcnt_reg <= 5'd30;
            end
            ST_WRAP: begin
                rem_reg  <= div_rem_new;
                dsr_reg  <= {dsr_reg[30:0], 1'b0};
                dcnt_reg <= dcnt_reg - 5'd1;
                if (div_last) time_reg <= $signed({1'b0, div_rem_new[30:0]});
            end
            ST_FIRST_CHK: begin
                ta_reg     <= kt;
                mode_a_reg <= key_rdata[33:32];
                base_a_reg <= comp_base(KAW'(0));
            end
            ST_LAST_CHK: begin
                idx_reg <= KAW'(1);
                if (time_reg >= kt) base_a_reg <= comp_base(n_last_reg);
            end
            ST_SCAN: begin
                if (time_reg <= kt) begin
                    ka_reg <= idx_reg - KAW'(1);
                    kb_reg <= idx_reg;
                    tb_reg <= kt;
                end else if (idx_reg == n_last_reg) begin
                    base_a_reg <= comp_base(n_last_reg);
                end else begin
                    ta_reg     <= kt;
                    mode_a_reg <= key_rdata[33:32];
                    idx_reg    <= idx_reg + KAW'(1);
                end
            end
            ST_FRAC: begin
                base_a_reg <= comp_base(ka_reg);
                base_b_reg <= comp_base(kb_reg);
                maxm_reg   <= 32'd0;
                t_reg      <= frac_low ? '0 : T_ONE;
                rem_reg    <= {1'b0, frac_num[31:1]};
                dsr_reg    <= {frac_num[0], 31'd0};
                dvs_reg    <= frac_den[31:0];
                dcnt_reg   <= DIV_STEPS;
            end
            ST_FRAC_DIV, ST_NORM_DIV: begin
                rem_reg  <= div_rem_new;
                dsr_reg  <= {dsr_reg[30:0], 1'b0};
                quo_reg  <= div_q_new;
                dcnt_reg <= dcnt_reg - 5'd1;
                if (div_last) begin
                    if (state_reg == ST_FRAC_DIV) begin
                        t_reg <= div_q_new;
                    end else begin
                        res_reg[ROT_BASE + int'(qsel_reg)] <= qneg_reg[qsel_reg]
                            ? -$signed(32'(div_q_new)) : $signed(32'(div_q_new));
                        qsel_reg <= qsel_reg + 2'd1;
                    end
                end
            end
            ST_SM_C: t_reg <= prod_sh[QW-1:0];
            ST_LB:   a_reg <= comp_rdata;
            ST_LS: begin
                res_reg[cidx_reg] <= lerp_val;
                cidx_reg <= cidx_reg + 4'd1;
                if (cidx_reg >= 4'(ROT_BASE) && cidx_reg <= 4'(ROT_LAST)) begin
                    qneg_reg[lerp_q] <= lerp_val[31];
                    qmag_reg[lerp_q] <= lerp_val[31] ? 32'(-lerp_val) : 32'(lerp_val);
                    if ((lerp_val[31] ? 32'(-lerp_val) : 32'(lerp_val)) > maxm_reg) begin
                        maxm_reg <= lerp_val[31] ? 32'(-lerp_val) : 32'(lerp_val);
                    end
                end
            end
            ST_HALVE: begin
                sum_reg  <= 64'd0;
                qsel_reg <= 2'd0;
                if (maxm_reg == 32'd0) begin
                    // zero quaternion: identity
                    for (int i = ROT_BASE; i < ROT_LAST; i++) res_reg[i] <= 32'sd0;
                    res_reg[ROT_LAST] <= $signed(32'(T_ONE));
                end else if (maxm_reg[31] || maxm_reg[30]) begin
                    // halve away from zero on the negative side
                    for (int i = 0; i < 4; i++) begin
                        qmag_reg[i] <= qneg_reg[i] ? 32'((33'(qmag_reg[i]) + 33'd1) >> 1)
                                                   : (qmag_reg[i] >> 1);
                    end
                end
            end
            ST_SQACC: begin
                sum_reg  <= sum_reg + prod_reg[63:0];
                qsel_reg <= qsel_reg + 2'd1;
                sx_reg   <= sum_reg + prod_reg[63:0];
                sr_reg   <= 64'd0;
                sbit_reg <= 64'd1 << 62;
                dcnt_reg <= 5'd31;
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    sx_reg <= sx_reg - sq_try;
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
                dcnt_reg <= dcnt_reg - 5'd1;
            end
            ST_NORM_START: begin
                rem_reg  <= {1'b0, qmag_reg[qsel_reg][31:1]};
                dsr_reg  <= {qmag_reg[qsel_reg][0], 31'd0};
                dvs_reg  <= sr_reg[31:0];
                dcnt_reg <= DIV_STEPS;
            end
            ST_RAW_WR: begin
                res_reg[cidx_reg] <= comp_rdata;
                cidx_reg <= cidx_reg + 4'd1;
            end
            default: a_reg <= a_reg;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            out_present_reg <= present_reg;
            for (int i = 0; i < NCOMP; i++) out_res_reg[i] <= res_reg[i];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_present = out_present_reg;
    assign m_trans_x = out_res_reg[0];
    assign m_trans_y = out_res_reg[1];
    assign m_trans_z = out_res_reg[2];
    assign m_rot_x   = out_res_reg[3];
    assign m_rot_y   = out_res_reg[4];
    assign m_rot_z   = out_res_reg[5];
    assign m_rot_w   = out_res_reg[6];
    assign m_scale_x = out_res_reg[7];
    assign m_scale_y = out_res_reg[8];
    assign m_scale_z = out_res_reg[9];

    // ---------------- assertions ----------------
    `KTS_ASSERT_NEXT(a_done_loads_out, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg)
    `KTS_ASSERT_SAME(a_len_nonzero, state_reg == ST_NORM_START, sr_reg != 64'd0)
    `KTS_ASSERT_SAME(a_t_in_range, state_reg == ST_LM, t_reg <= T_ONE)

endmodule

`default_nettype wire

>>> test/kts_tb_pkg.sv
// ----------------------------------------------------------------------------
// kts_tb_pkg
// Word codes and the predicted result shape shared by the sampler testbench.
// ----------------------------------------------------------------------------
package kts_tb_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] MODE_LINEAR = 2'd1;

    localparam int NUM_KEYS  = 16;
    localparam int NUM_COMPS = 10;

    typedef struct {
        logic                present;
        logic signed [31:0]  comp [NUM_COMPS];
    } pose_t;

endpackage

>>> test/keyframe_transform_sampler_checker.sv
// ----------------------------------------------------------------------------
// keyframe_transform_sampler_checker
// Watches the APB port and both word channels, keeps a shadow key table,
// predicts each sampled pose and compares it with the result words in order.
// ----------------------------------------------------------------------------
module keyframe_transform_sampler_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_opcode,
    input  logic [3:0]         s_key_index,
    input  logic signed [31:0] s_key_stamp,
    input  logic [1:0]         s_key_mode,
    input  logic [3:0]         s_component_index,
    input  logic signed [31:0] s_component_value,
    input  logic signed [31:0] s_sample_time,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_present,
    input  logic signed [31:0] m_comp [kts_tb_pkg::NUM_COMPS],
    output int                 fail_count,
    output int                 pending
);
    import kts_pkg::*;
    import kts_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = 64'sd65536;

    logic signed [31:0] key_time [NUM_KEYS];
    logic [1:0]         key_mode [NUM_KEYS];
    logic signed [31:0] key_comp [NUM_KEYS][NUM_COMPS];
    logic [4:0]         key_count;
    logic [30:0]        clip_len;
    pose_t              expected_poses [$];

    function automatic logic signed [31:0] sat32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint isqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // nlerp tail: renormalize components 3..6 in place
    function automatic void renormalize(ref pose_t p);
        longint c [4];
        longint mag [4];
        longint maxm;
        longint sum;
        longint len;
        longint r;
        maxm = 0;
        sum  = 0;
        for (int i = 0; i < 4; i++) begin
            c[i]   = longint'(p.comp[ROT_BASE + i]);
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        if (maxm == 0) begin
            for (int i = 0; i < 3; i++) p.comp[ROT_BASE + i] = 0;
            p.comp[ROT_LAST] = ONE[31:0];
            return;
        end
        if (maxm >= (64'sd1 <<< 30)) begin
            for (int i = 0; i < 4; i++) begin
                c[i]   = c[i] >>> 1;
                mag[i] = c[i] < 0 ? -c[i] : c[i];
            end
        end
        for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
        len = isqrt(longint'(sum));
        if (len == 0) len = 1;
        for (int i = 0; i < 4; i++) begin
            r = (mag[i] <<< 16) / len;
            p.comp[ROT_BASE + i] = sat32(c[i] < 0 ? -r : r);
        end
    endfunction

    function automatic void blend_keys(input int ka, input int kb, input longint tm,
                                       ref pose_t p);
        longint ta;
        longint tb;
        longint num;
        longint den;
        longint t;
        longint u;
        longint a;
        longint b;
        ta = longint'(key_time[ka]);
        tb = longint'(key_time[kb]);
        if (tb <= ta || key_mode[ka] == MODE_STEP) begin
            p.comp = key_comp[ka];
            return;
        end
        num = tm - ta;
        den = tb - ta;
        if (num <= 0) t = 0;
        else if (num >= den) t = ONE;
        else t = (num <<< 16) / den;
        if (key_mode[ka] == MODE_SMOOTH) begin
            u = (t * t) >>> 16;
            t = (u * (3 * ONE - 2 * t)) >>> 16;
        end
        for (int i = 0; i < NUM_COMPS; i++) begin
            a = longint'(key_comp[ka][i]);
            b = longint'(key_comp[kb][i]);
            p.comp[i] = sat32(a + (((b - a) * t) >>> 16));
        end
        renormalize(p);
    endfunction

    function automatic pose_t predict_pose(input logic signed [31:0] t_in);
        pose_t  p;
        longint tm;
        int     n;
        int     sel;
        bit     found;
        p.present = 1'b0;
        foreach (p.comp[i]) p.comp[i] = 0;
        n = key_count > NUM_KEYS ? NUM_KEYS : int'(key_count);
        if (n == 0) return p;
        p.present = 1'b1;
        tm = longint'(t_in);
        if (clip_len != 0) begin
            if (tm < 0) tm = 0;
            tm = tm % longint'({1'b0, clip_len});
        end
        found = 1'b0;
        sel   = n - 1;
        if (tm <= longint'(key_time[0])) begin
            sel = 0;
        end else if (tm < longint'(key_time[n - 1])) begin
            for (int i = 1; i < n; i++) begin
                if (!found && tm <= longint'(key_time[i])) begin
                    blend_keys(i - 1, i, tm, p);
                    found = 1'b1;
                end
            end
        end
        if (!found) p.comp = key_comp[sel];
        return p;
    endfunction

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        $display("mismatch at %0t: %s got %08h expected %08h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pose_t want;
        if (!aresetn) begin
            key_count  <= '0;
            clip_len   <= '0;
            fail_count = 0;
            expected_poses.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_KEY_COUNT) key_count <= pwdata[4:0];
                else clip_len <= pwdata[30:0];
            end
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    report("unexpected result word", 32'(m_present), 0);
                end else begin
                    want = expected_poses.pop_front();
                    if (m_present !== want.present)
                        report("present", 32'(m_present), 32'(want.present));
                    for (int i = 0; i < NUM_COMPS; i++)
                        if (m_comp[i] !== want.comp[i])
                            report($sformatf("component %0d", i), m_comp[i], want.comp[i]);
                end
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_SAMPLE) begin
                    expected_poses.push_back(predict_pose(s_sample_time));
                end else if (s_component_index < NUM_COMPS) begin
                    key_time[s_key_index] = s_key_stamp;
                    key_mode[s_key_index] = s_key_mode;
                    key_comp[s_key_index][s_component_index] = s_component_value;
                end
            end
        end
        pending <= expected_poses.size();
    end

endmodule

>>> test/keyframe_transform_sampler_top_tb.sv
// ----------------------------------------------------------------------------
// keyframe_transform_sampler_top_tb
// Builds key tracks of random shape, samples them under several key counts
// and clip lengths with bursty input and a stalling sink; the checker
// predicts every pose and this top gives the verdict.
// ----------------------------------------------------------------------------
module keyframe_transform_sampler_top_tb;
    import kts_pkg::*;
    import kts_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN       = 400;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_opcode;
    logic [3:0]         s_key_index;
    logic signed [31:0] s_key_stamp;
    logic [1:0]         s_key_mode;
    logic [3:0]         s_component_index;
    logic signed [31:0] s_component_value;
    logic signed [31:0] s_sample_time;
    logic               m_valid;
    logic               m_ready;
    logic               m_present;
    logic signed [31:0] m_comp [NUM_COMPS];
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 burst_left;
    int                 loads_sent;
    int                 samples_sent;
    int                 phases;
    logic signed [31:0] stamps [NUM_KEYS];

    keyframe_transform_sampler_top i_dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_opcode, .s_key_index, .s_key_stamp, .s_key_mode,
        .s_component_index, .s_component_value, .s_sample_time,
        .m_valid, .m_ready, .m_present,
        .m_trans_x(m_comp[0]), .m_trans_y(m_comp[1]), .m_trans_z(m_comp[2]),
        .m_rot_x(m_comp[3]), .m_rot_y(m_comp[4]), .m_rot_z(m_comp[5]),
        .m_rot_w(m_comp[6]), .m_scale_x(m_comp[7]), .m_scale_y(m_comp[8]),
        .m_scale_z(m_comp[9])
    );

    keyframe_transform_sampler_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // sink stall pattern: rotate through four styles over time
    always @(posedge aclk) begin
        int style;
        style = (cycles / 64) % 4;
        case (style)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(1, 0) == 1);
            2: m_ready <= ($urandom_range(3, 0) == 0);
            default: m_ready <= ((cycles % 9) < 5);
        endcase
    end

    task automatic send_word(input logic op, input logic [3:0] ki, input logic signed [31:0] st,
                             input logic [1:0] md, input logic [3:0] ci,
                             input logic signed [31:0] cv, input logic signed [31:0] tm);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            burst_left = $urandom_range(24, 1);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_opcode          <= op;
        s_key_index       <= ki;
        s_key_stamp       <= st;
        s_key_mode        <= md;
        s_component_index <= ci;
        s_component_value <= cv;
        s_sample_time     <= tm;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_SAMPLE) samples_sent++;
        else loads_sent++;
    endtask

    task automatic sample_at(input logic signed [31:0] tm);
        send_word(OP_SAMPLE, 4'($urandom), $urandom, 2'($urandom), 4'($urandom), $urandom, tm);
    endtask

    // hold off until every result has come and the block has gone quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_component(input bit zero_rot, input int ci);
        int pick;
        if (zero_rot && ci >= ROT_BASE && ci <= ROT_LAST) return 0;
        pick = $urandom_range(9, 0);
        case (pick)
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            3: return 0;
            default: return $signed($urandom_range(32'h40000, 0)) - 32'sh20000;
        endcase
    endfunction

    // write all ten components of keys 0..nkeys-1
    task automatic build_track(input int nkeys);
        int          base;
        int          style;
        bit          zero_rot;
        logic [1:0]  md;
        style    = $urandom_range(5, 0);
        zero_rot = ($urandom_range(7, 0) == 0);
        base     = (style == 0) ? -$urandom_range(32'h100000, 0) : $urandom_range(32'h40000, 0);
        for (int k = 0; k < nkeys; k++) begin
            if (style == 1) stamps[k] = $urandom;
            else if (style == 2 && k > 0 && $urandom_range(3, 0) == 0) stamps[k] = stamps[k - 1];
            else stamps[k] = base + k * 32'h20000 + $urandom_range(32'h1ffff, 0);
            md = 2'($urandom);
            for (int ci = 0; ci < NUM_COMPS; ci++)
                send_word(OP_LOAD, 4'(k), stamps[k], md, 4'(ci),
                          pick_component(zero_rot, ci), $urandom);
        end
    endtask

    function automatic logic signed [31:0] pick_time(input int nkeys);
        int pick;
        int k;
        pick = $urandom_range(9, 0);
        k    = $urandom_range(nkeys - 1, 0);
        case (pick)
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            3: return stamps[k];
            default: return stamps[k] + $signed($urandom_range(32'h3ffff, 0)) - 32'sh8000;
        endcase
    endfunction

    initial begin
        int           nkeys;
        int           nsamples;
        logic [31:0]  clip;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_opcode = OP_LOAD; s_key_index = '0; s_key_stamp = '0;
        s_key_mode = '0; s_component_index = '0; s_component_value = '0; s_sample_time = '0;
        m_ready = 1'b0;
        cycles = 0; burst_left = 0; loads_sent = 0; samples_sent = 0; phases = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty track, then loads with a bad component slot
        sample_at(32'sh7fffffff);
        sample_at(32'sh80000000);
        send_word(OP_LOAD, 4'd5, 32'sh1234, MODE_LINEAR, 4'd10, 32'sh5555, 0);
        send_word(OP_LOAD, 4'd15, 32'sh1234, MODE_LINEAR, 4'd15, 32'sh5555, 0);
        // two keys: extreme values, large rotation forces the halving path
        for (int ci = 0; ci < NUM_COMPS; ci++)
            send_word(OP_LOAD, 4'd0, 32'sh10000, MODE_SMOOTH, 4'(ci),
                      (ci >= ROT_BASE && ci <= ROT_LAST) ? 32'sh0 : 32'sh80000000, 0);
        for (int ci = 0; ci < NUM_COMPS; ci++)
            send_word(OP_LOAD, 4'd1, 32'sh30000, MODE_LINEAR, 4'(ci), 32'sh7fffffff, 0);
        stamps[0] = 32'sh10000;
        stamps[1] = 32'sh30000;
        drain_results();
        write_reg(REG_KEY_COUNT, 32'd2);
        sample_at(32'sh80000000);
        sample_at(32'sh10000);
        sample_at(32'sh10001);
        sample_at(32'sh20000);
        sample_at(32'sh30000);
        sample_at(32'sh7fffffff);
        drain_results();
        write_reg(REG_CLIP_DURATION, 32'h7fffffff);
        sample_at(32'sh80000000);
        sample_at(32'sh2ffff);

        // random tracks, each under a new key count and clip length
        while (loads_sent + samples_sent < ITEM_TARGET) begin
            drain_results();
            nkeys = ($urandom_range(3, 0) == 0) ? NUM_KEYS : $urandom_range(6, 1);
            build_track(nkeys);
            drain_results();
            write_reg(REG_KEY_COUNT,
                      (nkeys == NUM_KEYS && $urandom_range(1, 0) == 1) ? 32'd31 : 32'(nkeys));
            case ($urandom_range(3, 0))
                0: clip = 32'h0;
                1: clip = 32'h7fffffff;
                2: clip = $urandom_range(32'h7fffffff, 1);
                default: clip = 32'(stamps[nkeys - 1]) + $urandom_range(32'h30000, 1);
            endcase
            write_reg(REG_CLIP_DURATION, clip & 32'h7fffffff);
            nsamples = $urandom_range(50, 20);
            for (int i = 0; i < nsamples; i++) begin
                if ($urandom_range(9, 0) == 0)
                    send_word(OP_LOAD, 4'($urandom), $urandom, 2'($urandom),
                              4'($urandom_range(15, 10)), $urandom, $urandom);
                else
                    sample_at(pick_time(nkeys));
            end
            phases++;
        end

        drain_results();
        $display("covered %0d loads and %0d samples over %0d random tracks",
                 loads_sent, samples_sent, phases);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
